@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

@@ rtl/pbkdf_pkg.sv @@
// Package with types, constants and SHA-256 helpers for the PIN key derivation block.
package pbkdf_pkg;

  typedef struct packed {
    logic [31:0] pin_chars;
    logic [63:0] salt_high;
    logic [63:0] salt_low;
  } pbkdf_in_t;

  typedef struct packed {
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
    logic        status;
  } pbkdf_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } pbkdf_state_t;

  // Which compression is running.
  typedef enum logic [2:0] {
    PH_IPAD,
    PH_OPAD,
    PH_INNER,
    PH_OUTER
  } pbkdf_phase_t;

  localparam logic [19:0] ITER_RESET = 20'd100000;
  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_NINE  = 8'h39;
  localparam logic [31:0] IPAD_WORD  = 32'h36363636;
  localparam logic [31:0] OPAD_WORD  = 32'h5c5c5c5c;
  localparam logic [31:0] PAD_WORD   = 32'h80000000;
  localparam logic [31:0] LEN_SALT   = 32'd672;
  localparam logic [31:0] LEN_DIGEST = 32'd768;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] sha_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ rtl/pbkdf_core.sv @@
// One-round-per-cycle SHA-256 compression unit shared by every hash of a derivation.
module pbkdf_core
  import pbkdf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [255:0] chain_in,
  input  logic [511:0] block_in,
  output logic         done,
  output logic [255:0] digest
);
  `include "assert_macros.svh"

  logic         busy_r, busy_nxt;
  logic [5:0]   rnd_r, rnd_nxt;
  logic [255:0] chain_r, chain_nxt;
  logic [255:0] work_r, work_nxt;
  logic [511:0] sched_r, sched_nxt;
  logic         done_r, done_nxt;

  logic [31:0] a, b, c, d, e, f, g, h, w0, t1, t2, s0, s1, wnew;

  always_comb begin
    {a, b, c, d, e, f, g, h} = work_r;
    w0 = sched_r[511:480];
    t1 = h + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25)) + ((e & f) ^ (~e & g))
       + sha_k(rnd_r) + w0;
    t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    // Message schedule kept as a 16-word window; word 1 is w[i-15], word 14 is w[i-2].
    s0 = rotr32(sched_r[479:448], 7) ^ rotr32(sched_r[479:448], 18)
       ^ (sched_r[479:448] >> 3);
    s1 = rotr32(sched_r[63:32], 17) ^ rotr32(sched_r[63:32], 19) ^ (sched_r[63:32] >> 10);
    wnew = w0 + s0 + sched_r[223:192] + s1;

    busy_nxt  = busy_r;
    rnd_nxt   = rnd_r;
    chain_nxt = chain_r;
    work_nxt  = work_r;
    sched_nxt = sched_r;
    done_nxt  = 1'b0;
    if (start && !busy_r) begin
      busy_nxt  = 1'b1;
      rnd_nxt   = 6'd0;
      chain_nxt = chain_in;
      work_nxt  = chain_in;
      sched_nxt = block_in;
    end else if (busy_r) begin
      work_nxt  = {t1 + t2, a, b, c, d + t1, e, f, g};
      sched_nxt = {sched_r[479:0], wnew};
      rnd_nxt   = rnd_r + 6'd1;
      if (rnd_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      rnd_r  <= rnd_nxt;
    end
    chain_r <= chain_nxt;
    work_r  <= work_nxt;
    sched_r <= sched_nxt;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      digest[32*i +: 32] = chain_r[32*i +: 32] + work_r[32*i +: 32];
    end
  end
  assign done = done_r;

  `CHK_NEXT(a_done_after_last, clk, rst_n, busy_r && rnd_r == 6'd63, done_r && !busy_r)
  `CHK_IMPL(a_done_not_busy, clk, rst_n, done_r, !busy_r)
endmodule

@@ rtl/pbkdf2_hmac_sha256_pin_kdf.sv @@
// Top level of the PBKDF2-HMAC-SHA256 PIN key derivation block.
// Usage: an input transaction on in_valid/in_ready carries the PIN characters
// and a 128-bit salt. The block first checks that each of the PIN_LENGTH
// characters is an ASCII decimal digit. If one is not, the result carries a
// zero key and status 1. Otherwise it precomputes the inner and outer pad
// chaining values (two compressions) and then runs two compressions per HMAC
// iteration, all on one SHA-256 round unit that does one round per cycle.
// Each compression starts from the load state and runs its 64 rounds; after
// the outer compression of the last iteration the key is registered, and
// out_valid then rises by way of the final state.
// The block holds in_ready low from acceptance until the result transaction on
// out_valid/out_ready completes; the result register holds steady while the
// receiver stalls. A cfg_we pulse writes iteration_count, which should only
// change while idle; a count of zero acts as one. Synchronous reset (rst_n low)
// returns the sequencer to idle, drops out_valid and sets the count to 100000.
module pbkdf2_hmac_sha256_pin_kdf
  import pbkdf_pkg::*;
#(
  parameter int PIN_LENGTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pbkdf_in_t   in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pbkdf_out_t  out_data,
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata
);
  `include "assert_macros.svh"

  pbkdf_state_t state_r, state_nxt;
  pbkdf_phase_t phase_r, phase_nxt;
  logic [19:0]  iter_r, iter_nxt;
  logic [19:0]  left_r, left_nxt;
  logic         first_r, first_nxt;
  logic [31:0]  pin_r, pin_nxt;
  logic [127:0] salt_r, salt_nxt;
  logic [255:0] ist_r, ist_nxt, ost_r, ost_nxt;
  logic [255:0] u_r, u_nxt, acc_r, acc_nxt;
  pbkdf_out_t   res_r, res_nxt;
  logic         ov_r, ov_nxt;

  logic         core_start, core_done;
  logic [255:0] core_chain, core_dig;
  logic [511:0] core_blk;
  logic         pin_ok;
  logic [511:0] key_blk;
  logic [255:0] acc_new;

  // Digit check; characters beyond the 32-bit field read as zero bytes.
  always_comb begin
    logic [7:0] ch;
    pin_ok = 1'b1;
    for (int i = 0; i < PIN_LENGTH; i++) begin
      ch = (i >= PIN_LENGTH - 4) ? in_data.pin_chars[8*(PIN_LENGTH-1-i) +: 8] : 8'h00;
      if (ch < CHAR_ZERO || ch > CHAR_NINE) pin_ok = 1'b0;
    end
  end

  // Key block: PIN bytes first, zero padded to 64 bytes.
  always_comb begin
    key_blk = '0;
    for (int i = 0; i < PIN_LENGTH && i < 4; i++) begin
      key_blk[511-8*i -: 8] = pin_r[8*(PIN_LENGTH-1-i) +: 8];
    end
  end

  // Running XOR of the HMAC iterates including the digest just produced.
  assign acc_new = first_r ? core_dig : (acc_r ^ core_dig);

  always_comb begin
    core_chain = SHA_IV;
    core_blk   = key_blk;
    case (phase_r)
      PH_IPAD: begin
        core_chain = SHA_IV;
        core_blk   = key_blk ^ {16{IPAD_WORD}};
      end
      PH_OPAD: begin
        core_chain = SHA_IV;
        core_blk   = key_blk ^ {16{OPAD_WORD}};
      end
      PH_INNER: begin
        core_chain = ist_r;
        core_blk   = first_r ? {salt_r, 32'd1, PAD_WORD, 288'd0, LEN_SALT}
                             : {u_r, PAD_WORD, 192'd0, LEN_DIGEST};
      end
      PH_OUTER: begin
        core_chain = ost_r;
        core_blk   = {u_r, PAD_WORD, 192'd0, LEN_DIGEST};
      end
      default: begin
        core_chain = SHA_IV;
        core_blk   = key_blk;
      end
    endcase
  end

  pbkdf_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (core_start),
    .chain_in (core_chain),
    .block_in (core_blk),
    .done     (core_done),
    .digest   (core_dig)
  );

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    iter_nxt   = cfg_we ? cfg_wdata : iter_r;
    left_nxt   = left_r;
    first_nxt  = first_r;
    pin_nxt    = pin_r;
    salt_nxt   = salt_r;
    ist_nxt    = ist_r;
    ost_nxt    = ost_r;
    u_nxt      = u_r;
    acc_nxt    = acc_r;
    res_nxt    = res_r;
    ov_nxt     = ov_r;
    core_start = 1'b0;
    in_ready   = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pin_nxt   = in_data.pin_chars;
          salt_nxt  = {in_data.salt_high, in_data.salt_low};
          left_nxt  = (iter_r == 20'd0) ? 20'd1 : iter_r;
          first_nxt = 1'b1;
          phase_nxt = PH_IPAD;
          if (pin_ok) begin
            state_nxt = ST_LOAD;
          end else begin
            res_nxt   = '0;
            res_nxt.status = 1'b1;
            state_nxt = ST_FINAL;
          end
        end
      end
      ST_LOAD: begin
        core_start = 1'b1;
        state_nxt  = ST_ROUND;
      end
      ST_ROUND: begin
        if (core_done) begin
          state_nxt = ST_LOAD;
          case (phase_r)
            PH_IPAD: begin
              ist_nxt   = core_dig;
              phase_nxt = PH_OPAD;
            end
            PH_OPAD: begin
              ost_nxt   = core_dig;
              phase_nxt = PH_INNER;
            end
            PH_INNER: begin
              u_nxt     = core_dig;
              phase_nxt = PH_OUTER;
            end
            PH_OUTER: begin
              u_nxt     = core_dig;
              acc_nxt   = acc_new;
              first_nxt = 1'b0;
              left_nxt  = left_r - 20'd1;
              phase_nxt = PH_INNER;
              if (left_r == 20'd1) begin
                res_nxt.key_word0 = acc_new[255:192];
                res_nxt.key_word1 = acc_new[191:128];
                res_nxt.key_word2 = acc_new[127:64];
                res_nxt.key_word3 = acc_new[63:0];
                res_nxt.status    = 1'b0;
                state_nxt         = ST_FINAL;
              end
            end
            default: phase_nxt = PH_IPAD;
          endcase
        end
      end
      ST_FINAL: begin
        ov_nxt    = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          ov_nxt    = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_IPAD;
      iter_r  <= ITER_RESET;
      ov_r    <= 1'b0;
      first_r <= 1'b1;
      left_r  <= 20'd0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      iter_r  <= iter_nxt;
      ov_r    <= ov_nxt;
      first_r <= first_nxt;
      left_r  <= left_nxt;
    end
    pin_r  <= pin_nxt;
    salt_r <= salt_nxt;
    ist_r  <= ist_nxt;
    ost_r  <= ost_nxt;
    u_r    <= u_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = res_r;

  `CHK_IMPL(a_valid_in_out, clk, rst_n, ov_r, state_r == ST_OUT)
  `CHK_IMPL(a_no_accept_busy, clk, rst_n, ov_r, !in_ready)
  `CHK_NEXT(a_out_hold, clk, rst_n, ov_r && !out_ready, ov_r && $stable(res_r))
endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the PBKDF2-HMAC-SHA256 PIN key derivation block.
module testbench;
  import pbkdf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The instance uses the default PIN length of four characters.
  localparam int PIN_CHARS = 4;
  localparam logic [19:0] COUNT_MAX = 20'hFFFFF;
  // Cycles the block is left alone before a register write.
  localparam int SETTLE_CYCLES = 8;

  // One entry of the stimulus plan: either a register write or an input item.
  typedef struct {
    bit          is_cfg;
    logic [19:0] count;
    pbkdf_in_t   item;
  } plan_entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pbkdf_in_t   in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pbkdf_out_t  out_data;
  logic        cfg_we = 1'b0;
  logic [19:0] cfg_wdata = '0;

  plan_entry_t plan_q[$];
  pbkdf_out_t  key_q[$];
  logic [19:0] iter_count_model;
  int          error_count = 0;
  bit          in_fired = 1'b0;
  int          send_gap = 0;
  int          burst_left = 0;
  int          settle = 0;
  int          stall_left = 0;

  pbkdf2_hmac_sha256_pin_kdf dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor: a plain SHA-256 compression and the PBKDF2 block built on it.
  // Word 0 of a state or message block sits in the most significant bits.
  // ---------------------------------------------------------------------
  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] compress(input logic [255:0] chain,
                                            input logic [511:0] blk);
    logic [31:0] round_k[64];
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] s0, s1, t1, t2;
    logic [255:0] res;
    round_k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain[255 - 32*i -: 32];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) res[255 - 32*i -: 32] = chain[255 - 32*i -: 32] + v[i];
    return res;
  endfunction

  // One HMAC over a 32-byte digest, given the precomputed pad chains.
  function automatic logic [255:0] hmac_digest(input logic [255:0] ichain,
                                               input logic [255:0] ochain,
                                               input logic [255:0] msg);
    logic [255:0] inner;
    inner = compress(ichain, {msg, 32'h80000000, 192'd0, 32'd768});
    return compress(ochain, {inner, 32'h80000000, 192'd0, 32'd768});
  endfunction

  function automatic pbkdf_out_t derive_key(input pbkdf_in_t x, input logic [19:0] count);
    logic [255:0] iv_chain, ichain, ochain, u, acc, inner;
    logic [511:0] key_blk;
    logic [7:0]   ch;
    logic [19:0]  rounds;
    pbkdf_out_t   r;
    r = '0;
    for (int i = 0; i < PIN_CHARS; i++) begin
      ch = x.pin_chars[8*(PIN_CHARS-1-i) +: 8];
      if (ch < 8'h30 || ch > 8'h39) r.status = 1'b1;
    end
    if (r.status) return r;
    iv_chain = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    // The four PIN bytes fill the first key word; the rest of the key is zero.
    key_blk = {x.pin_chars, 480'd0};
    ichain = compress(iv_chain, key_blk ^ {16{32'h36363636}});
    ochain = compress(iv_chain, key_blk ^ {16{32'h5c5c5c5c}});
    inner = compress(ichain, {x.salt_high, x.salt_low, 32'd1, 32'h80000000,
                              288'd0, 32'd672});
    u = compress(ochain, {inner, 32'h80000000, 192'd0, 32'd768});
    acc = u;
    rounds = (count == 0) ? 20'd1 : count;
    for (int n = 1; n < rounds; n++) begin
      u = hmac_digest(ichain, ochain, u);
      acc ^= u;
    end
    {r.key_word0, r.key_word1, r.key_word2, r.key_word3} = acc;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  task automatic add_item(input logic [31:0] pin, input logic [63:0] hi,
                          input logic [63:0] lo);
    plan_entry_t e;
    e.is_cfg = 1'b0;
    e.count = '0;
    e.item.pin_chars = pin;
    e.item.salt_high = hi;
    e.item.salt_low = lo;
    plan_q.push_back(e);
  endtask

  task automatic add_cfg(input logic [19:0] count);
    plan_entry_t e;
    e.is_cfg = 1'b1;
    e.count = count;
    e.item = '0;
    plan_q.push_back(e);
  endtask

  function automatic logic [31:0] digit_pin();
    logic [31:0] p;
    for (int i = 0; i < 4; i++) p[8*i +: 8] = 8'h30 + 8'($urandom_range(0, 9));
    return p;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // A PIN that fails the digit check: either fully random or a digit PIN
  // with one character pushed just outside the digit range or to any byte.
  function automatic logic [31:0] bad_pin();
    logic [31:0] p;
    logic [7:0]  ch;
    int          pos;
    bit          all_digits;
    if ($urandom_range(0, 2) == 0) begin
      p = $urandom;
    end else begin
      p = digit_pin();
      case ($urandom_range(0, 2))
        0: ch = 8'h2f;
        1: ch = 8'h3a;
        default: ch = 8'($urandom_range(0, 255));
      endcase
      pos = $urandom_range(0, 3);
      p[8*pos +: 8] = ch;
    end
    // A random draw can still land on four digits; push the last one out.
    all_digits = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (p[8*i +: 8] < 8'h30 || p[8*i +: 8] > 8'h39) all_digits = 1'b0;
    end
    if (all_digits) p[7:0] = 8'h2f;
    return p;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  // ---------------------------------------------------------------------
  // Monitor: on the rising edge, predict each accepted input transaction,
  // check each accepted result transaction, and track register writes.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    pbkdf_out_t want;
    in_fired <= in_valid && in_ready;
    if (rst_n) begin
      if (cfg_we) iter_count_model <= cfg_wdata;
      if (in_valid && in_ready) key_q.push_back(derive_key(in_data, iter_count_model));
      if (out_valid && out_ready) begin
        if (key_q.size() == 0) begin
          $display("MISMATCH: unexpected result transaction at %0t", $realtime);
          error_count++;
        end else begin
          want = key_q.pop_front();
          if (out_data.key_word0 !== want.key_word0)
            report_mismatch("key_word0", out_data.key_word0, want.key_word0);
          if (out_data.key_word1 !== want.key_word1)
            report_mismatch("key_word1", out_data.key_word1, want.key_word1);
          if (out_data.key_word2 !== want.key_word2)
            report_mismatch("key_word2", out_data.key_word2, want.key_word2);
          if (out_data.key_word3 !== want.key_word3)
            report_mismatch("key_word3", out_data.key_word3, want.key_word3);
          if (out_data.status !== want.status)
            report_mismatch("status", {63'd0, out_data.status}, {63'd0, want.status});
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver: on the falling edge, pull the next plan entry. A register write
  // waits until the block has returned every result and sat quiet a while.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    logic        next_valid;
    logic        next_we;
    plan_entry_t head;
    next_valid = in_valid;
    next_we = 1'b0;
    if (in_fired) next_valid = 1'b0;
    if (rst_n && !next_valid) begin
      if (plan_q.size() != 0 && plan_q[0].is_cfg) begin
        if (key_q.size() != 0) begin
          settle = 0;
        end else if (settle < SETTLE_CYCLES) begin
          settle++;
        end else begin
          head = plan_q.pop_front();
          next_we = 1'b1;
          cfg_wdata <= head.count;
          settle = 0;
        end
      end else if (send_gap > 0) begin
        send_gap--;
      end else if (plan_q.size() != 0) begin
        head = plan_q.pop_front();
        next_valid = 1'b1;
        in_data <= head.item;
        // Gaps are mostly short with a few long ones, and now and then a
        // burst of back-to-back transactions.
        if (burst_left > 0) begin
          burst_left--;
          send_gap = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          burst_left = $urandom_range(4, 12);
          send_gap = 0;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: send_gap = 0;
            4, 5, 6, 7, 8: send_gap = $urandom_range(1, 4);
            default: send_gap = $urandom_range(15, 80);
          endcase
        end
      end
    end
    in_valid <= next_valid;
    cfg_we <= next_we;

    // The receiver stalls in runs of random length, mostly short.
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Plan, reset and end of run.
  // ---------------------------------------------------------------------
  initial begin
    logic [19:0] count;
    iter_count_model = ITER_RESET;

    // At the reset count of 100000 a valid PIN would run far too long, so
    // this phase checks the digit filter alone: zeros, all ones, the characters
    // just below and above the digit range in every position, and 0xB0 bytes.
    add_item(32'h00000000, 64'd0, 64'd0);
    add_item(32'hFFFFFFFF, '1, '1);
    for (int pos = 0; pos < 4; pos++) begin
      add_item(32'h39393939 & ~(32'hFF << (8*pos)) | (32'h2f << (8*pos)), rand64(), rand64());
      add_item(32'h30303030 & ~(32'hFF << (8*pos)) | (32'h3a << (8*pos)), rand64(), rand64());
    end
    add_item(32'hB0B0B0B0, rand64(), rand64());

    // Smallest count: digit extremes with extreme salts.
    add_cfg(20'd1);
    add_item(32'h30303030, 64'd0, 64'd0);
    add_item(32'h39393939, '1, '1);
    add_item(32'h39303930, '1, 64'd0);
    add_item(digit_pin(), 64'd0, '1);
    add_item(32'h31323334, rand64(), rand64());

    // A count of zero behaves as one.
    add_cfg(20'd0);
    add_item(32'h30303030, 64'd0, 64'd0);
    add_item(digit_pin(), rand64(), rand64());

    // Largest count, with non-digit PINs only so the run stays short.
    add_cfg(COUNT_MAX);
    add_item(bad_pin(), rand64(), rand64());
    add_item(32'h2f2f2f2f, rand64(), rand64());

    // Random phases at small counts, most PINs well formed.
    for (int ph = 0; ph < 5; ph++) begin
      count = 20'($urandom_range(1, 6));
      add_cfg(count);
      for (int n = 0; n < 20; n++) begin
        if ($urandom_range(0, 3) != 0) add_item(digit_pin(), rand64(), rand64());
        else add_item(bad_pin(), rand64(), rand64());
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (plan_q.size() != 0 || in_valid || key_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("pbkdf2_hmac_sha256_pin_kdf verification clean");
    end else begin
      $display("pbkdf2_hmac_sha256_pin_kdf verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run of this plan.
  initial begin
    #5000000;
    $display("pbkdf2_hmac_sha256_pin_kdf verification failed");
    $finish;
  end

endmodule
